/* rtl/ws_spi_pkg.sv */
// ----------------------------------------------------------------------------
// ws_spi_pkg
// Shared types and constants for the ws2812 spi pixel encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ws_spi_pkg;

  // spi words standing for one led bit
  localparam logic [15:0] WORD_ONE  = 16'h7F00;
  localparam logic [15:0] WORD_ZERO = 16'h7000;
  localparam logic [15:0] WORD_GAP  = 16'h0000;

  // color words per pixel: green, red, blue, eight bits each
  localparam int DATA_WORDS = 24;
  localparam int DATA_CNT_W = 5;

  // defaults for top-level parameters
  localparam int RESET_WORDS_DEF = 20;
  localparam int QUEUE_DEPTH_DEF = 2;

  // one classified pixel waiting for the serializer
  typedef struct packed {
    logic [23:0] grb;   // scaled channels in send order, green in 23:16
    logic        last;  // frame ends after this pixel
  } pixel_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

/* rtl/ws_spi_front.sv */
// ----------------------------------------------------------------------------
// ws_spi_front
// Input side: holds brightness, scales the channels and reorders them.
// ----------------------------------------------------------------------------
`default_nettype none

module ws_spi_front
  import ws_spi_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,
  input  wire logic        s_tlast,
  input  wire q_status_t   q_status,
  output logic             push,
  output pixel_t           push_data
);

  logic [7:0]  brightness;
  logic [15:0] prod_r;
  logic [15:0] prod_g;
  logic [15:0] prod_b;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;

  // brightness register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= 8'd0;
    end else if (cfg_valid) begin
      brightness <= cfg_data;
    end
  end

  // channel scaling, zero brightness passes through
  always_comb begin
    prod_r = s_tdata[23:16] * brightness;
    prod_g = s_tdata[15:8] * brightness;
    prod_b = s_tdata[7:0] * brightness;
    if (brightness == 8'd0) begin
      red   = s_tdata[23:16];
      green = s_tdata[15:8];
      blue  = s_tdata[7:0];
    end else begin
      red   = prod_r[15:8];
      green = prod_g[15:8];
      blue  = prod_b[15:8];
    end
  end

  // push into the queue whenever there is room
  assign s_tready       = !q_status.full;
  assign push           = s_tvalid && !q_status.full;
  assign push_data.grb  = {green, red, blue};
  assign push_data.last = s_tlast;

endmodule

`default_nettype wire

/* rtl/ws_spi_queue.sv */
// ----------------------------------------------------------------------------
// ws_spi_queue
// Small first-in first-out queue of classified pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module ws_spi_queue
  import ws_spi_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire pixel_t push_data,
  input  wire logic   pop,
  output pixel_t      pop_data,
  output q_status_t   q_status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pixel_t             mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign q_status.full  = (count == CNT_W'(DEPTH));
  assign q_status.empty = (count == '0);
  assign pop_data       = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/ws_spi_back.sv */
// ----------------------------------------------------------------------------
// ws_spi_back
// Output side: serializes each pixel into spi words and adds the reset gap.
// ----------------------------------------------------------------------------
`default_nettype none

module ws_spi_back
  import ws_spi_pkg::*;
#(
  parameter int RESET_WORDS = RESET_WORDS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire q_status_t   q_status,
  input  wire pixel_t      pop_data,
  output logic             pop,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,
  output logic             m_tlast
);

  localparam int GAP_W = $clog2(RESET_WORDS + 1);

  logic                  busy;
  logic                  in_gap;
  logic                  last;
  logic [22:0]           shift;
  logic [DATA_CNT_W-1:0] data_cnt;
  logic [GAP_W-1:0]      gap_cnt;
  logic                  advance;

  // output register free or being drained
  assign advance = !m_tvalid || m_tready;
  assign pop     = advance && !busy && !q_status.empty;

  // serializer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      in_gap   <= 1'b0;
      m_tvalid <= 1'b0;
      data_cnt <= '0;
      gap_cnt  <= '0;
    end else if (advance) begin
      if (busy && !in_gap) begin
        m_tvalid <= 1'b1;
        m_tdata  <= shift[22] ? WORD_ONE : WORD_ZERO;
        m_tlast  <= 1'b0;
        shift    <= {shift[21:0], 1'b0};
        data_cnt <= data_cnt + 1'b1;
        if (data_cnt == DATA_CNT_W'(DATA_WORDS - 1)) begin
          if (last) begin
            in_gap  <= 1'b1;
            gap_cnt <= '0;
          end else begin
            busy <= 1'b0;
          end
        end
      end else if (busy) begin
        m_tvalid <= 1'b1;
        m_tdata  <= WORD_GAP;
        m_tlast  <= (gap_cnt == GAP_W'(RESET_WORDS - 1));
        gap_cnt  <= gap_cnt + 1'b1;
        if (gap_cnt == GAP_W'(RESET_WORDS - 1)) begin
          busy   <= 1'b0;
          in_gap <= 1'b0;
        end
      end else if (!q_status.empty) begin
        // first bit goes out in the same beat as the pop
        m_tvalid <= 1'b1;
        m_tdata  <= pop_data.grb[23] ? WORD_ONE : WORD_ZERO;
        m_tlast  <= 1'b0;
        shift    <= pop_data.grb[22:0];
        last     <= pop_data.last;
        data_cnt <= DATA_CNT_W'(1);
        busy     <= 1'b1;
      end else begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/ws2812_spi_pixel_encoder.sv */
// ----------------------------------------------------------------------------
// ws2812_spi_pixel_encoder
// Turns packed rgb pixels into 16-bit spi words for a ws2812 led string.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one beat per pixel, s_tdata = color (red 23:16, green 15:8,
//   blue 7:0), s_tlast marks the final pixel of a frame.
//   m_* channel: one spi word per beat, 0x7F00 for a one bit, 0x7000 for a
//   zero bit, green then red then blue, msb first; after a last pixel
//   RESET_WORDS zero words follow, m_tlast set on the final one.
//   cfg_* channel: brightness, written by the user only while the block is
//   idle, not enforced by the block; zero sends colors unscaled, otherwise
//   each channel becomes (c*b)>>8.
// Rate: one word per cycle while m_tready is not held low; a pixel is 24
//   words, a last pixel 24 + RESET_WORDS, and the next pixel is taken only
//   after that; each pixel passes the queue, then the output register.
// Reset: clears brightness, the queue and the output register.
// Stall: a held m_tready freezes the output word; the queue keeps taking
//   pixels until QUEUE_DEPTH wait, then s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module ws2812_spi_pixel_encoder
  import ws_spi_pkg::*;
#(
  parameter int RESET_WORDS = RESET_WORDS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data,   // brightness
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,    // pixel_color
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,    // spi_word
  output logic             m_tlast
);

  q_status_t q_status;
  logic      push;
  logic      pop;
  pixel_t    push_data;
  pixel_t    pop_data;

  // accept and scale
  ws_spi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  // decoupling queue
  ws_spi_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_status  (q_status)
  );

  // serialize
  ws_spi_back #(
    .RESET_WORDS (RESET_WORDS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .pop_data (pop_data),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

/* rtl/ws_spi_checker.sv */
// ----------------------------------------------------------------------------
// ws_spi_checker
// Port-level checks for the ws2812 spi pixel encoder.
// ----------------------------------------------------------------------------
`default_nettype none

module ws_spi_checker
  import ws_spi_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic        m_tlast
);

  // output beat is empty right after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("m_tvalid high after reset");

  // frame end only on a gap word
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata == WORD_GAP))
    else $error("frame end on a data word");

  // only the three legal word codes appear
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata == WORD_ONE || m_tdata == WORD_ZERO || m_tdata == WORD_GAP))
    else $error("illegal spi word");

  // stalled beat holds
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("output changed under stall");

endmodule

bind ws2812_spi_pixel_encoder ws_spi_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire
